FILE: rtl/sfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Types and constants shared by the serial frame deframer modules.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam logic [7:0] ByteAck = 8'h06;
  localparam logic [7:0] ByteSof = 8'h01;
  localparam logic [7:0] SumInit = 8'hff;
  localparam logic [7:0] MaxPayloadReset = 8'd254;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_LEN   = 2'd1,
    PH_DATA  = 2'd2,
    PH_CHECK = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    KIND_DATA   = 3'd0,
    KIND_GOOD   = 3'd1,
    KIND_BADSUM = 3'd2,
    KIND_STRAY  = 3'd3,
    KIND_BADLEN = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } result_t;

endpackage

FILE: rtl/sfd_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_out_buf
// Output register with a skid stage; full drives the upstream stall.
// ----------------------------------------------------------------------------
module sfd_out_buf import sfd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  result_t in_data_i,
  output logic    full_o,
  output logic    out_valid_o,
  output result_t out_data_o,
  input  logic    out_stall_i
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_data_q, out_data_d;
  result_t skid_data_q, skid_data_d;
  logic    out_fire;

  assign out_fire = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (in_valid_i) begin
      if (!out_valid_q || out_fire) begin
        out_valid_d = 1'b1;
        out_data_d  = in_data_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_data_d  = in_data_i;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held without an output word");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && out_fire |=> out_valid_q && !skid_valid_q)
    else $error("skid word not moved to output");

endmodule

FILE: rtl/serial_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_deframer
// Splits received serial bytes into frames: start, length, payload and
// XOR checksum; reports payload bytes, frame status and stray bytes.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Word
// rx        in         rx_valid_i/rx_stall_o   rx_byte_i
// res       out        res_valid_o/res_stall_i kind_o, payload_byte_o
// cfg       in         APB psel/penable        max_payload at 0x0
//
// One byte per cycle while rx_stall_o is low; results are registered.
// The frame state updates in the cycle a byte is taken.
// rx_stall_o rises only when both output and skid registers hold words.
// Reset: idle, checksum 0xff, max_payload 254, no word pending.
// ----------------------------------------------------------------------------
module serial_frame_deframer import sfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  phase_e     phase_q, phase_d;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] max_payload_q;
  logic       rx_accept;
  logic       res_new;
  result_t    res_new_data;
  result_t    res_out;
  logic       buf_full;
  logic [7:0] count;
  logic [7:0] left_dec;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'd0, max_payload_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MaxPayloadReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      max_payload_q <= pwdata[7:0];
    end
  end

  assign rx_accept = rx_valid_i && !rx_stall_o;
  assign count     = rx_byte_i - 8'd1;
  assign left_dec  = (bytes_left_q != 8'd0) ? bytes_left_q - 8'd1 : bytes_left_q;

  always_comb begin
    phase_d           = phase_q;
    bytes_left_d      = bytes_left_q;
    sum_d             = sum_q;
    res_new           = 1'b0;
    res_new_data.kind = KIND_STRAY;
    res_new_data.data = rx_byte_i;
    if (rx_accept) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (rx_byte_i == ByteSof) begin
            sum_d        = SumInit;
            bytes_left_d = 8'd0;
            phase_d      = PH_LEN;
          end else if (rx_byte_i != ByteAck) begin
            res_new = 1'b1;
          end
        end
        PH_LEN: begin
          if (rx_byte_i == 8'd0 || count > max_payload_q) begin
            phase_d           = PH_IDLE;
            sum_d             = SumInit;
            res_new           = 1'b1;
            res_new_data.kind = KIND_BADLEN;
          end else begin
            sum_d        = sum_q ^ rx_byte_i;
            bytes_left_d = count;
            phase_d      = (count == 8'd0) ? PH_CHECK : PH_DATA;
          end
        end
        PH_DATA: begin
          sum_d             = sum_q ^ rx_byte_i;
          bytes_left_d      = left_dec;
          if (left_dec == 8'd0) begin
            phase_d = PH_CHECK;
          end
          res_new           = 1'b1;
          res_new_data.kind = KIND_DATA;
        end
        PH_CHECK: begin
          phase_d           = PH_IDLE;
          bytes_left_d      = 8'd0;
          sum_d             = SumInit;
          res_new           = 1'b1;
          res_new_data.kind = (rx_byte_i == sum_q) ? KIND_GOOD : KIND_BADSUM;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      bytes_left_q <= 8'd0;
      sum_q        <= SumInit;
    end else begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      sum_q        <= sum_d;
    end
  end

  sfd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_new),
    .in_data_i   (res_new_data),
    .full_o      (buf_full),
    .out_valid_o (res_valid_o),
    .out_data_o  (res_out),
    .out_stall_i (res_stall_i)
  );

  assign rx_stall_o     = buf_full;
  assign kind_o         = res_out.kind;
  assign payload_byte_o = res_out.data;

  a_data_has_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> bytes_left_q != 8'd0)
    else $error("payload phase with no bytes left");

  a_sof_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_accept && phase_q == PH_IDLE && rx_byte_i == ByteSof
    |=> phase_q == PH_LEN && sum_q == SumInit)
    else $error("start byte did not open a frame");

  a_check_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_accept && phase_q == PH_CHECK
    |=> phase_q == PH_IDLE && sum_q == SumInit && res_valid_o)
    else $error("checksum byte did not close the frame");

endmodule
